/* rtl/lpd_pkg.sv */
// Shared types and constants for the length-prefixed packet deframer.
`timescale 1ns / 1ps

package lpd_pkg;

    localparam logic [7:0] SIGNATURE_BYTE = 8'h7F;

    typedef logic [2:0] t_phase;
    localparam t_phase PHASE_SIG     = 3'd0;
    localparam t_phase PHASE_LEN0    = 3'd1;
    localparam t_phase PHASE_LEN1    = 3'd2;
    localparam t_phase PHASE_LEN2    = 3'd3;
    localparam t_phase PHASE_LEN3    = 3'd4;
    localparam t_phase PHASE_PAYLOAD = 3'd5;

    typedef logic [2:0] t_status;
    localparam t_status ST_PAYLOAD  = 3'd0;
    localparam t_status ST_EMPTY    = 3'd1;
    localparam t_status ST_BAD_SIG  = 3'd2;
    localparam t_status ST_TOO_LONG = 3'd3;
    localparam t_status ST_LINK     = 3'd4;

    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       link_down;
        logic       clear;
    } t_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last;
        t_status    status;
    } t_result;

endpackage

/* rtl/lpd_in_stage.sv */
// Input register stage: holds one transfer until the framer takes it.
`timescale 1ns / 1ps

module lpd_in_stage
    import lpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_adv,
    output logic  o_fire,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign o_stall = r_valid && !i_adv;
    assign load    = !o_stall;
    assign o_fire  = r_valid && i_adv;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/lpd_frame.sv */
// Header tracking, error latch and payload counting for one byte per cycle while the input stage fires.
`timescale 1ns / 1ps

module lpd_frame
    import lpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic [31:0] i_max_payload,
    output logic        o_res_valid,
    output t_result     o_result
);

    t_phase      r_phase,     n_phase;
    logic        r_sig_ok,    n_sig_ok;
    logic [31:0] r_len_acc,   n_len_acc;
    logic [31:0] r_remaining, n_remaining;
    logic        r_err,       n_err;

    logic [31:0] full_len;
    logic [31:0] rem_dec;

    assign full_len = {i_item.rx_byte, r_len_acc[23:0]};
    assign rem_dec  = r_remaining - 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_sig_ok    = r_sig_ok;
        n_len_acc   = r_len_acc;
        n_remaining = r_remaining;
        n_err       = r_err;
        o_res_valid = 1'b0;
        o_result    = '{payload_byte: 8'd0, last: 1'b0, status: ST_PAYLOAD};

        if (i_item.link_down) begin
            n_err       = 1'b1;
            n_phase     = PHASE_SIG;
            n_sig_ok    = 1'b0;
            n_len_acc   = '0;
            n_remaining = '0;
            o_res_valid = !r_err;
            o_result.status = ST_LINK;
        end else if (i_item.clear) begin
            n_err       = 1'b0;
            n_phase     = PHASE_SIG;
            n_sig_ok    = 1'b0;
            n_len_acc   = '0;
            n_remaining = '0;
        end else if (!r_err) begin
            case (r_phase)
                PHASE_PAYLOAD: begin
                    n_remaining = rem_dec;
                    o_res_valid = 1'b1;
                    o_result.payload_byte = i_item.rx_byte;
                    if (rem_dec == 32'd0) begin
                        o_result.last = 1'b1;
                        n_phase       = PHASE_SIG;
                        n_sig_ok      = 1'b0;
                        n_len_acc     = '0;
                    end
                end
                PHASE_LEN0: begin
                    n_len_acc = {r_len_acc[31:8], i_item.rx_byte};
                    n_phase   = PHASE_LEN1;
                end
                PHASE_LEN1: begin
                    n_len_acc = {r_len_acc[31:16], i_item.rx_byte, r_len_acc[7:0]};
                    n_phase   = PHASE_LEN2;
                end
                PHASE_LEN2: begin
                    n_len_acc = {r_len_acc[31:24], i_item.rx_byte, r_len_acc[15:0]};
                    n_phase   = PHASE_LEN3;
                end
                PHASE_LEN3: begin
                    n_phase     = PHASE_SIG;
                    n_sig_ok    = 1'b0;
                    n_len_acc   = '0;
                    n_remaining = '0;
                    o_res_valid = 1'b1;
                    if (!r_sig_ok) begin
                        n_err           = 1'b1;
                        o_result.status = ST_BAD_SIG;
                    end else if (full_len > i_max_payload) begin
                        n_err           = 1'b1;
                        o_result.status = ST_TOO_LONG;
                    end else if (full_len == 32'd0) begin
                        o_result.last   = 1'b1;
                        o_result.status = ST_EMPTY;
                    end else begin
                        o_res_valid = 1'b0;
                        n_remaining = full_len;
                        n_phase     = PHASE_PAYLOAD;
                    end
                end
                default: begin
                    // signature byte; unused phase codes restart here too
                    n_sig_ok  = (i_item.rx_byte == SIGNATURE_BYTE);
                    n_len_acc = '0;
                    n_phase   = PHASE_LEN0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_SIG;
            r_sig_ok    <= 1'b0;
            r_len_acc   <= '0;
            r_remaining <= '0;
            r_err       <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_sig_ok    <= n_sig_ok;
            r_len_acc   <= n_len_acc;
            r_remaining <= n_remaining;
            r_err       <= n_err;
        end
    end

endmodule

/* rtl/length_prefixed_packet_deframer_core.sv */
// Top level of the length-prefixed packet deframer.
//
// Input channel: i_valid/o_stall carry one received byte per transfer with
// its link-down and clear flags. Output channel: o_valid/i_stall carry
// payload bytes and status results (empty packet, bad signature, length over
// limit, link failure). A header is a 0x7F signature then a 32-bit
// little-endian length; after a good header the payload bytes pass through,
// the final one marked with o_last.
// Path: a result is registered in the input register, then in the result
// register. Throughput: one byte per cycle while i_stall does not hold the
// output, set by the single framer step between the two registers.
// Bytes causing no result are consumed without an output transfer.
// When i_stall is high with a result waiting, the result holds, and o_stall
// rises once the input register is also full; nothing is lost.
// Reset (synchronous, i_rst_n low) empties both registers, clears the error
// latch and framing state, and sets max_payload to 1048576.
// max_payload sits at APB address 0; write it only while the block is idle.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_core
    import lpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_link_down,
    input  logic        i_clear,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_item       in_item;
    t_item       stage_item;
    logic        adv;
    logic        fire;
    logic        res_valid;
    t_result     result;
    logic        r_out_valid;
    t_result     r_out;
    logic [31:0] r_max_payload;

    assign in_item = '{rx_byte: i_rx_byte, link_down: i_link_down, clear: i_clear};
    assign adv     = !r_out_valid || !i_stall;

    lpd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .o_stall (o_stall),
        .i_adv   (adv),
        .o_fire  (fire),
        .o_item  (stage_item)
    );

    lpd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (stage_item),
        .i_max_payload (r_max_payload),
        .o_res_valid   (res_valid),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && fire && res_valid) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out.payload_byte;
    assign o_last         = r_out.last;
    assign o_status       = r_out.status;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD)) begin
            r_max_payload <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_PAYLOAD: prdata = r_max_payload;
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* dv/length_prefixed_packet_deframer_core_test.sv */
// Self-checking testbench for the length-prefixed packet deframer core.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer_core_test;
    import lpd_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 6;
    localparam int PHASE_ITEMS  = 380;

    class deframer_scoreboard;
        logic [31:0] payload_limit;
        t_phase      frame_phase;
        bit          sig_good;
        logic [31:0] len_gathered;
        logic [31:0] bytes_left;
        bit          err_latched;
        t_result     due_results[$];
        int          errors;

        function new();
            payload_limit = MAX_PAYLOAD_RESET;
            err_latched   = 1'b0;
            errors        = 0;
            restart();
        endfunction

        function void restart();
            frame_phase  = PHASE_SIG;
            sig_good     = 1'b0;
            len_gathered = '0;
            bytes_left   = '0;
        endfunction

        // Works out the result, if any, of one accepted input transfer.
        function void note_transfer(t_item it);
            t_result r;
            bit      has;
            int      shift;
            r   = '0;
            has = 1'b0;
            if (it.link_down) begin
                has         = !err_latched;
                r.status    = ST_LINK;
                err_latched = 1'b1;
                restart();
            end else if (it.clear) begin
                restart();
                err_latched = 1'b0;
            end else if (!err_latched) begin
                if (frame_phase == PHASE_PAYLOAD) begin
                    bytes_left     = bytes_left - 32'd1;
                    r.payload_byte = it.rx_byte;
                    r.status       = ST_PAYLOAD;
                    r.last         = (bytes_left == 32'd0);
                    has            = 1'b1;
                    if (r.last)
                        restart();
                end else begin
                    if (frame_phase > PHASE_PAYLOAD)
                        frame_phase = PHASE_SIG;
                    if (frame_phase == PHASE_SIG) begin
                        sig_good     = (it.rx_byte == SIGNATURE_BYTE);
                        len_gathered = '0;
                        frame_phase  = PHASE_LEN0;
                    end else begin
                        shift        = 8 * (int'(frame_phase) - 1);
                        len_gathered = len_gathered | ({24'd0, it.rx_byte} << shift);
                        if (frame_phase != PHASE_LEN3) begin
                            frame_phase = frame_phase + 3'd1;
                        end else if (!sig_good) begin
                            err_latched = 1'b1;
                            restart();
                            r.status = ST_BAD_SIG;
                            has      = 1'b1;
                        end else if (len_gathered > payload_limit) begin
                            err_latched = 1'b1;
                            restart();
                            r.status = ST_TOO_LONG;
                            has      = 1'b1;
                        end else if (len_gathered == 32'd0) begin
                            restart();
                            r.status = ST_EMPTY;
                            r.last   = 1'b1;
                            has      = 1'b1;
                        end else begin
                            bytes_left  = len_gathered;
                            frame_phase = PHASE_PAYLOAD;
                        end
                    end
                end
            end
            if (has)
                due_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("unexpected result: payload_byte %0d last %0d status %0d",
                       got.payload_byte, got.last, got.status);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.payload_byte !== want.payload_byte) begin
                $error("payload_byte: expected %0d, got %0d", want.payload_byte,
                       got.payload_byte);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic        i_link_down;
    logic        i_clear;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_payload_byte;
    logic        o_last;
    logic [2:0]  o_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    deframer_scoreboard sb;

    int unsigned counted_items;
    int unsigned gap_mode;
    bit          calm;
    int          hold_request;
    int          idle_cycles;

    length_prefixed_packet_deframer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_link_down    (i_link_down),
        .i_clear        (i_clear),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: check transfers and drive stall bursts.
    initial begin : result_side
        int stall_left;
        int hold_left;
        int stall_mode;
        int mode_cycles;
        bit stall_next;
        stall_left  = 0;
        hold_left   = 0;
        stall_mode  = 0;
        mode_cycles = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_result('{o_payload_byte, o_last, o_status});
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = 64;
            end
            mode_cycles--;
            stall_next = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (calm || stall_mode == 0) begin
                stall_left = 0;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if ($urandom_range(0, stall_mode == 1 ? 9 : 3) == 0) begin
                stall_left = $urandom_range(0, 9);
                stall_next = 1'b1;
            end
            i_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("length_prefixed_packet_deframer_core regression: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic ld, input logic clr);
        t_item it;
        if (counted_items % 50 == 0)
            gap_mode = $urandom_range(0, 2);
        if (!calm && gap_mode != 0 && $urandom_range(0, gap_mode == 1 ? 9 : 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_rx_byte   <= b;
        i_link_down <= ld;
        i_clear     <= clr;
        do
            @(posedge i_clk);
        while (o_stall);
        it.rx_byte   = b;
        it.link_down = ld;
        it.clear     = clr;
        sb.note_transfer(it);
        if (!clr && !ld)
            counted_items++;
    endtask

    task automatic send_header(input logic [7:0] sig, input logic [31:0] len);
        send_item(sig, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++)
            send_item(len[8*i +: 8], 1'b0, 1'b0);
    endtask

    task automatic send_payload(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_item(8'($urandom), 1'b0, 1'b0);
    endtask

    task automatic resync();
        send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Wait for all results, then let any result-less transfer drain.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max_payload(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_PAYLOAD, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.payload_limit = value;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_len(input logic [31:0] lim);
        logic [31:0] cap;
        cap = (lim < 32'd8) ? lim : 32'd8;
        if ($urandom_range(0, 9) == 0)
            cap = (lim < 32'd40) ? lim : 32'd40;
        return $urandom_range(0, cap);
    endfunction

    task automatic run_traffic(input int unsigned target);
        int unsigned goal;
        int unsigned pick;
        logic [31:0] lim;
        logic [31:0] len;
        logic [7:0]  sig;
        goal = counted_items + target;
        lim  = sb.payload_limit;
        while (counted_items < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                // well-formed packet, usually from a clean framer
                if ((sb.err_latched || sb.frame_phase != PHASE_SIG) && $urandom_range(0, 7) != 0)
                    resync();
                len = pick_len(lim);
                send_header(SIGNATURE_BYTE, len);
                send_payload(len);
            end else if (pick < 72) begin
                if (lim == 32'hFFFF_FFFF) begin
                    len = $urandom;
                    sig = 8'($urandom_range(0, 126));
                end else begin
                    len = $urandom;
                    if (len <= lim)
                        len = lim + 32'd1;
                    sig = SIGNATURE_BYTE;
                end
                send_header(sig, len);
                if ($urandom_range(0, 3) != 0)
                    resync();
            end else if (pick < 80) begin
                sig = 8'($urandom);
                if (sig == SIGNATURE_BYTE)
                    sig = 8'h00;
                send_header(sig, $urandom);
                if ($urandom_range(0, 3) != 0)
                    resync();
            end else if (pick < 88) begin
                // packet cut short by a link failure or a clear
                if ($urandom_range(0, 1) == 0 && lim == 32'hFFFF_FFFF)
                    len = $urandom | 32'd64;
                else
                    len = $urandom_range(2, 20);
                send_header(SIGNATURE_BYTE, len);
                send_payload($urandom_range(0, 1));
                send_payload($urandom_range(0, 8));
                if ($urandom_range(0, 1) == 0) begin
                    send_item(8'($urandom), 1'b1, 1'($urandom));
                    if ($urandom_range(0, 3) != 0)
                        resync();
                end else begin
                    resync();
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(8'($urandom), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
                resync();
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] limits[5];
        sb            = new();
        counted_items = 0;
        gap_mode      = 0;
        calm          = 1'b0;
        hold_request  = 0;
        limits        = '{32'd1048576, 32'd0, 32'd16, 32'hFFFF_FFFF, 32'd5};

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_rx_byte   <= '0;
        i_link_down <= 1'b0;
        i_clear     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset limit, each status and the error latch rules
        send_header(SIGNATURE_BYTE, 32'd1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_header(SIGNATURE_BYTE, 32'd0);
        send_header(8'h00, 32'd1);
        send_item(SIGNATURE_BYTE, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_header(SIGNATURE_BYTE, 32'h0010_0001);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_header(SIGNATURE_BYTE, 32'd2);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_max_payload(limits[p]);
            if (p == 4)
                calm = 1'b1;
            if (p == 2)
                hold_request = HOLD_CYCLES;
            resync();
            if (p == 3) begin
                send_header(SIGNATURE_BYTE, 32'hFFFF_FFFF);
                send_payload(3);
                resync();
            end
            if (p == 1)
                send_header(SIGNATURE_BYTE, 32'd1);
            run_traffic(PHASE_ITEMS);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("length_prefixed_packet_deframer_core regression: pass");
        else
            $display("length_prefixed_packet_deframer_core regression: fail");
        $finish;
    end

endmodule
